[design/ascs_pkg.sv]
// Shared types, codes and constants of the converter scan sequencer.
`default_nettype none
package ascs_pkg;

  localparam int unsigned DEF_NUM_CHANNELS = 16;
  localparam int unsigned DEF_NUM_PORTS    = 4;
  localparam int unsigned DEF_SAMPLE_BITS  = 10;

  localparam int unsigned CMD_W     = 16;
  localparam int unsigned VALUE_W   = 13;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  // Millivolt scaling: full scale in microvolts, divide by 1000 by reciprocal.
  localparam int unsigned FULL_SCALE_UV = 5000000;
  localparam int unsigned MV_DIV        = 1000;
  localparam int unsigned MV_PROD_W     = 23;
  localparam int unsigned RECIP_SHIFT   = 32;

  // Converter command fields.
  localparam logic [3:0] MODE_MANUAL = 4'h1;
  localparam logic [3:0] MODE_AUTO   = 4'h2;
  localparam logic       PROG_ENABLE = 1'b1;
  localparam logic       RANGE_5V    = 1'b1;
  localparam logic [CMD_W-1:0] CMD_AUTO = {MODE_AUTO, PROG_ENABLE, 4'h0, RANGE_5V, 6'h00};

  localparam logic [1:0] LAST_READING = 2'd3;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_COLOR_MASK = 2'd0;
  localparam logic [1:0] REG_PORT_MAP   = 2'd1;
  localparam logic [1:0] REG_SENSORS    = 2'd2;

  localparam logic [1:0] INTERVAL_SLOW  = 2'd0;
  localparam logic [1:0] INTERVAL_FAST  = 2'd1;
  localparam logic [1:0] INTERVAL_COLOR = 2'd2;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_SINGLE = 3'd1,
    REQ_SCAN   = 3'd2,
    REQ_VOLT   = 3'd3,
    REQ_COLOR  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_VOLT,
    RD_COLOR
  } rd_kind_e;

  // Everything of a result except the value read from storage.
  typedef struct packed {
    logic             cmd_valid;
    logic [CMD_W-1:0] cmd_word;
    logic             use_scan;
    logic [1:0]       interval;
    logic             frame_done;
    logic             stopped;
    rd_kind_e         rd_kind;
  } meta_t;

  // Storage accesses of one request.
  typedef struct packed {
    logic       ch_we;
    logic [3:0] ch_waddr;
    logic       col_we;
    logic [3:0] col_waddr;
    logic       ch_re;
    logic [3:0] ch_raddr;
    logic       col_re;
    logic [3:0] col_raddr;
  } mem_req_t;

  function automatic logic [CMD_W-1:0] cmd_manual(input logic [3:0] pch);
    return {MODE_MANUAL, PROG_ENABLE, pch, RANGE_5V, 6'h00};
  endfunction

endpackage
`default_nettype wire

[design/adc_scan_color_sequencer.sv]
// Top level of the converter scan and color sequencer.
`default_nettype none
// Takes one request per clock: timer ticks, single replies, scan words and
// voltage or color reads, each giving exactly one result. The sample memories
// are read at the accepting edge, then the millivolt scaling multiplies by the
// LSB size, multiplies by the reciprocal of 1000, and applies the one-step
// correction into the output register, each step in its own register stage.
// Requests flow back to back; input ready drops only when all four result
// stages are held by a stalled output. Sample memories read as zero until
// written; no clearing pass is needed after reset. Configuration writes
// through the APB port are to be made while no request is in flight.
module adc_scan_color_sequencer import ascs_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int unsigned NUM_PORTS    = DEF_NUM_PORTS,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2:0]          req_type_i,
  input  wire logic [15:0]         rx_word_i,
  input  wire logic                last_word_i,
  input  wire logic                spi_error_i,
  input  wire logic [3:0]          channel_i,
  input  wire logic [1:0]          port_i,
  input  wire logic [1:0]          color_step_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     command_valid_o,
  output logic      [CMD_W-1:0]    command_word_o,
  output logic                     use_scan_frame_o,
  output logic      [1:0]          interval_code_o,
  output logic                     frame_done_o,
  output logic      [VALUE_W-1:0]  read_value_o,
  output logic                     stopped_o
);

  logic                   acc;
  meta_t                  meta_in, meta_out;
  mem_req_t               mem_req;
  logic [SAMPLE_BITS-1:0] ch_wdata, col_wdata, rdata;

  assign pready = 1'b1;
  assign acc    = in_valid_i && in_ready_o;

  ascs_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_PORTS    (NUM_PORTS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .acc_i        (acc),
    .req_type_i   (req_type_i),
    .rx_word_i    (rx_word_i),
    .last_word_i  (last_word_i),
    .spi_error_i  (spi_error_i),
    .channel_i    (channel_i),
    .port_i       (port_i),
    .color_step_i (color_step_i),
    .meta_o       (meta_in),
    .mem_req_o    (mem_req),
    .ch_wdata_o   (ch_wdata),
    .col_wdata_o  (col_wdata)
  );

  ascs_store #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_PORTS    (NUM_PORTS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .mem_req_i   (mem_req),
    .ch_wdata_i  (ch_wdata),
    .col_wdata_i (col_wdata),
    .rdata_o     (rdata)
  );

  ascs_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .meta_i       (meta_in),
    .rdata_i      (rdata),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .meta_o       (meta_out),
    .read_value_o (read_value_o)
  );

  assign command_valid_o  = meta_out.cmd_valid;
  assign command_word_o   = meta_out.cmd_word;
  assign use_scan_frame_o = meta_out.use_scan;
  assign interval_code_o  = meta_out.interval;
  assign frame_done_o     = meta_out.frame_done;
  assign stopped_o        = meta_out.stopped;

endmodule
`default_nettype wire

[design/ascs_ctrl.sv]
// Sequencer control: registers, command issue, port stepping and storage requests.
`default_nettype none
module ascs_ctrl import ascs_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int unsigned NUM_PORTS    = DEF_NUM_PORTS,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_AW-1:0]      paddr,
  input  wire logic [APB_DW-1:0]      pwdata,
  output logic      [APB_DW-1:0]      prdata,
  input  wire logic                   acc_i,
  input  wire logic [2:0]             req_type_i,
  input  wire logic [15:0]            rx_word_i,
  input  wire logic                   last_word_i,
  input  wire logic                   spi_error_i,
  input  wire logic [3:0]             channel_i,
  input  wire logic [1:0]             port_i,
  input  wire logic [1:0]             color_step_i,
  output meta_t                       meta_o,
  output mem_req_t                    mem_req_o,
  output logic      [SAMPLE_BITS-1:0] ch_wdata_o,
  output logic      [SAMPLE_BITS-1:0] col_wdata_o
);

  logic [3:0]  mask_q;
  logic [15:0] map_q;
  logic        sensors_q;

  logic       scan_q, scan_d;
  logic       busy_q, busy_d;
  logic       halted_q, halted_d;
  logic [1:0] cpi_q, cpi_d;
  logic [1:0] cri_q, cri_d;

  logic       is_color;
  logic       manual;
  logic [3:0] pch;
  logic [1:0] cpi_inc;
  logic [1:0] next_port;
  logic [3:0] wch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      map_q     <= '0;
      sensors_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_COLOR_MASK: mask_q    <= pwdata[3:0];
        REG_PORT_MAP:   map_q     <= pwdata[15:0];
        REG_SENSORS:    sensors_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COLOR_MASK: prdata = {28'h0, mask_q};
      REG_PORT_MAP:   prdata = {16'h0, map_q};
      REG_SENSORS:    prdata = {31'h0, sensors_q};
      default:        prdata = '0;
    endcase
  end

  assign is_color  = mask_q[cpi_q];
  assign pch       = map_q[{cpi_q, 2'b00} +: 4];
  assign manual    = is_color && (cri_q != LAST_READING);
  assign cpi_inc   = cpi_q + 2'd1;
  assign next_port = (int'(cpi_inc) >= NUM_PORTS) ? 2'd0 : cpi_inc;
  assign wch       = rx_word_i[15:12];

  assign ch_wdata_o  = rx_word_i[11 -: SAMPLE_BITS];
  assign col_wdata_o = rx_word_i[SAMPLE_BITS-1:0];

  always_comb begin
    scan_d    = scan_q;
    busy_d    = busy_q;
    halted_d  = halted_q;
    cpi_d     = cpi_q;
    cri_d     = cri_q;
    meta_o    = '0;
    meta_o.rd_kind = RD_NONE;
    mem_req_o = '0;
    case (req_type_i)
      REQ_TICK: begin
        if (!halted_q) begin
          if (!sensors_q) begin
            meta_o.interval = INTERVAL_SLOW;
          end else if (is_color) begin
            meta_o.interval = INTERVAL_COLOR;
          end else begin
            meta_o.interval = INTERVAL_FAST;
          end
          if (!busy_q) begin
            meta_o.cmd_valid = 1'b1;
            meta_o.cmd_word  = manual ? cmd_manual(pch) : CMD_AUTO;
            meta_o.use_scan  = scan_q;
            scan_d           = !manual;
            busy_d           = 1'b1;
          end
        end
      end
      REQ_SINGLE: begin
        if (!halted_q) begin
          if (spi_error_i) begin
            halted_d = 1'b1;
          end else if (is_color) begin
            mem_req_o.col_we    = int'(cpi_q) < NUM_PORTS;
            mem_req_o.col_waddr = {cpi_q, cri_q};
            cri_d               = cri_q + 2'd1;
            if (cri_q == LAST_READING) begin
              cpi_d = next_port;
            end
          end
          busy_d = 1'b0;
        end
      end
      REQ_SCAN: begin
        if (!halted_q) begin
          if (spi_error_i) begin
            halted_d = 1'b1;
            busy_d   = 1'b0;
          end else begin
            mem_req_o.ch_we    = int'(wch) < NUM_CHANNELS;
            mem_req_o.ch_waddr = wch;
            if (last_word_i) begin
              if (!is_color) begin
                cpi_d = next_port;
                cri_d = 2'd0;
              end
              meta_o.frame_done = 1'b1;
              busy_d            = 1'b0;
            end
          end
        end
      end
      REQ_VOLT: begin
        meta_o.rd_kind     = RD_VOLT;
        mem_req_o.ch_re    = int'(channel_i) < NUM_CHANNELS;
        mem_req_o.ch_raddr = channel_i;
      end
      REQ_COLOR: begin
        meta_o.rd_kind      = RD_COLOR;
        mem_req_o.col_re    = int'(port_i) < NUM_PORTS;
        mem_req_o.col_raddr = {port_i, color_step_i};
      end
      default: ;
    endcase
    meta_o.stopped = halted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= 1'b0;
      busy_q   <= 1'b0;
      halted_q <= 1'b0;
      cpi_q    <= '0;
      cri_q    <= '0;
    end else if (acc_i) begin
      scan_q   <= scan_d;
      busy_q   <= busy_d;
      halted_q <= halted_d;
      cpi_q    <= cpi_d;
      cri_q    <= cri_d;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("stop flag cleared without reset");
  a_port_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cpi_q) < NUM_PORTS) else $error("color port index out of range");
  a_cmd_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && meta_o.cmd_valid |=> busy_q && !halted_q)
    else $error("issued command did not mark transfer busy");
`endif

endmodule
`default_nettype wire

[design/ascs_store.sv]
// Channel and color sample memories with registered reads and reset-valid bits.
`default_nettype none
module ascs_store import ascs_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int unsigned NUM_PORTS    = DEF_NUM_PORTS,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   acc_i,
  input  wire mem_req_t               mem_req_i,
  input  wire logic [SAMPLE_BITS-1:0] ch_wdata_i,
  input  wire logic [SAMPLE_BITS-1:0] col_wdata_i,
  output logic      [SAMPLE_BITS-1:0] rdata_o
);

  localparam int unsigned COL_DEPTH = NUM_PORTS * 4;
  localparam int unsigned CW        = $clog2(NUM_CHANNELS);
  localparam int unsigned SW        = $clog2(COL_DEPTH);

  logic [SAMPLE_BITS-1:0] ch_mem  [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0] col_mem [COL_DEPTH];
  logic [NUM_CHANNELS-1:0] ch_vld_q;
  logic [COL_DEPTH-1:0]    col_vld_q;

  logic [SAMPLE_BITS-1:0] ch_rd_q;
  logic [SAMPLE_BITS-1:0] col_rd_q;
  logic                   hit_q;
  logic                   sel_col_q;

  logic [CW-1:0] ch_wa, ch_ra;
  logic [SW-1:0] col_wa, col_ra;

  assign ch_wa  = mem_req_i.ch_waddr[CW-1:0];
  assign ch_ra  = mem_req_i.ch_raddr[CW-1:0];
  assign col_wa = mem_req_i.col_waddr[SW-1:0];
  assign col_ra = mem_req_i.col_raddr[SW-1:0];

  // One request per cycle: a read never meets a write of the same request,
  // and earlier writes are already in the array, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (acc_i && mem_req_i.ch_we) begin
      ch_mem[ch_wa] <= ch_wdata_i;
    end
    if (acc_i && mem_req_i.col_we) begin
      col_mem[col_wa] <= col_wdata_i;
    end
    if (acc_i) begin
      ch_rd_q  <= ch_mem[ch_ra];
      col_rd_q <= col_mem[col_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_vld_q  <= '0;
      col_vld_q <= '0;
      hit_q     <= 1'b0;
      sel_col_q <= 1'b0;
    end else if (acc_i) begin
      if (mem_req_i.ch_we) begin
        ch_vld_q[ch_wa] <= 1'b1;
      end
      if (mem_req_i.col_we) begin
        col_vld_q[col_wa] <= 1'b1;
      end
      hit_q     <= (mem_req_i.ch_re && ch_vld_q[ch_ra]) ||
                   (mem_req_i.col_re && col_vld_q[col_ra]);
      sel_col_q <= mem_req_i.col_re;
    end
  end

  // Entries never written read as zero.
  assign rdata_o = !hit_q ? '0 : (sel_col_q ? col_rd_q : ch_rd_q);

endmodule
`default_nettype wire

[design/ascs_scale.sv]
// Result pipeline: millivolt scaling of channel reads and the output register.
`default_nettype none
module ascs_scale import ascs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   acc_i,
  input  wire meta_t                  meta_i,
  input  wire logic [SAMPLE_BITS-1:0] rdata_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output meta_t                       meta_o,
  output logic      [VALUE_W-1:0]     read_value_o
);

  localparam int unsigned PW = MV_PROD_W;
  localparam logic [PW-1:0] LSB_C =
    PW'(FULL_SCALE_UV / ((1 << SAMPLE_BITS) - 1));
  localparam logic [PW-1:0] RECIP_C = PW'((64'd1 << RECIP_SHIFT) / 64'd1000);
  localparam logic [PW-1:0] DIV_C   = PW'(MV_DIV);

  logic v1_q, v2_q, v3_q, ov_q;
  logic r1, r2, r3, r_out;
  meta_t m1_q, m2_q, m3_q, mo_q;
  logic [PW-1:0]      p2_q, p3_q, p2_d;
  logic [2*PW-1:0]    prod;
  logic [VALUE_W-1:0] q3_q, q3_d;
  logic [PW-1:0]      back, rem;
  logic [VALUE_W-1:0] q_fix;
  logic [VALUE_W-1:0] val_q, val_d;

  assign r_out = !ov_q || out_ready_i;
  assign r3    = !v3_q || r_out;
  assign r2    = !v2_q || r3;
  assign r1    = !v1_q || r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= acc_i;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
      if (r_out) begin
        ov_q <= v3_q;
      end
    end
  end

  // Microvolts, or the raw sample for color reads.
  assign p2_d = (m1_q.rd_kind == RD_VOLT) ? PW'(rdata_i) * LSB_C : PW'(rdata_i);

  // Quotient estimate by reciprocal; low by at most one.
  assign prod = {{PW{1'b0}}, p2_q} * {{PW{1'b0}}, RECIP_C};
  assign q3_d = prod[RECIP_SHIFT +: VALUE_W];

  assign back  = PW'(q3_q) * DIV_C;
  assign rem   = p3_q - back;
  assign q_fix = (rem >= DIV_C) ? q3_q + VALUE_W'(1) : q3_q;
  assign val_d = (m3_q.rd_kind == RD_VOLT) ? q_fix : p3_q[VALUE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      m1_q <= meta_i;
    end
    if (r2 && v1_q) begin
      m2_q <= m1_q;
      p2_q <= p2_d;
    end
    if (r3 && v2_q) begin
      m3_q <= m2_q;
      p3_q <= p2_q;
      q3_q <= q3_d;
    end
    if (r_out && v3_q) begin
      mo_q  <= m3_q;
      val_q <= val_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign meta_o       = mo_q;
  assign read_value_o = val_q;

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && ov_q))
    else $error("input blocked with a free pipeline slot");
  a_color_raw_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && (m2_q.rd_kind == RD_COLOR) |-> (p2_q >> SAMPLE_BITS) == '0)
    else $error("raw color value wider than a sample");
  a_mv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (m3_q.rd_kind == RD_VOLT) |-> rem < (DIV_C << 1))
    else $error("reciprocal estimate off by more than one");
`endif

endmodule
`default_nettype wire

[bench/adc_scan_color_sequencer_tb.sv]
// Self-checking testbench for the converter scan and color sequencer.
`timescale 1ns / 1ps
module adc_scan_color_sequencer_tb;
  import ascs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 6;

  // Request codes the block must ignore.
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  // Command words: mode in [15:12], program enable [11], channel [10:7], 5 V range [6].
  localparam logic [15:0] AUTO_SCAN_CMD   = 16'h2840;
  localparam logic [15:0] MANUAL_CMD_BASE = 16'h1840;
  localparam int unsigned UV_PER_CODE     = 5000000 / 1023;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] rx;
    logic        last;
    logic        err;
    logic [3:0]  chan;
    logic [1:0]  port;
    logic [1:0]  step;
  } request_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [15:0] cmd_word;
    logic        use_scan;
    logic [1:0]  interval;
    logic        frame_done;
    logic [12:0] value;
    logic        stopped;
  } result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [2:0]        req_type_i;
  logic [15:0]       rx_word_i;
  logic              last_word_i;
  logic              spi_error_i;
  logic [3:0]        channel_i;
  logic [1:0]        port_i;
  logic [1:0]        color_step_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              command_valid_o;
  logic [CMD_W-1:0]  command_word_o;
  logic              use_scan_frame_o;
  logic [1:0]        interval_code_o;
  logic              frame_done_o;
  logic [VALUE_W-1:0] read_value_o;
  logic              stopped_o;

  // Shadow configuration and sequencer state.
  logic [3:0]  color_mask_cfg;
  logic [15:0] port_map_cfg;
  logic        sensors_cfg;
  logic        scan_cmd_last;
  logic        busy;
  logic        halted;
  logic [1:0]  port_idx;
  logic [1:0]  reading_idx;
  logic [9:0]  chan_raw [16];
  logic [9:0]  color_raw [16];

  result_t pending_results [$];
  int      error_count;
  int      sent_count;
  int      hold_requests;
  bit      sender_gaps;
  bit      receiver_gaps;

  adc_scan_color_sequencer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .rx_word_i        (rx_word_i),
    .last_word_i      (last_word_i),
    .spi_error_i      (spi_error_i),
    .channel_i        (channel_i),
    .port_i           (port_i),
    .color_step_i     (color_step_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .command_valid_o  (command_valid_o),
    .command_word_o   (command_word_o),
    .use_scan_frame_o (use_scan_frame_o),
    .interval_code_o  (interval_code_o),
    .frame_done_o     (frame_done_o),
    .read_value_o     (read_value_o),
    .stopped_o        (stopped_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void advance_sequencer(input request_t q, output result_t r);
    logic       on_color;
    logic       manual;
    logic [3:0] pch;
    r = '0;
    on_color = color_mask_cfg[port_idx];
    case (q.kind)
      REQ_TICK: begin
        if (!halted) begin
          if (!sensors_cfg) r.interval = INTERVAL_SLOW;
          else if (on_color) r.interval = INTERVAL_COLOR;
          else r.interval = INTERVAL_FAST;
          if (!busy) begin
            manual = on_color && (reading_idx != LAST_READING);
            pch = port_map_cfg[port_idx*4 +: 4];
            r.cmd_word = manual ? (MANUAL_CMD_BASE | (16'(pch) << 7)) : AUTO_SCAN_CMD;
            // frame type follows the previous command
            r.use_scan = scan_cmd_last;
            scan_cmd_last = !manual;
            busy = 1'b1;
            r.cmd_valid = 1'b1;
          end
        end
      end
      REQ_SINGLE: begin
        if (!halted) begin
          if (q.err) begin
            halted = 1'b1;
          end else if (on_color) begin
            color_raw[{port_idx, reading_idx}] = q.rx[9:0];
            reading_idx = reading_idx + 2'd1;
            if (reading_idx == 2'd0) port_idx = port_idx + 2'd1;
          end
          busy = 1'b0;
        end
      end
      REQ_SCAN: begin
        if (!halted) begin
          if (q.err) begin
            halted = 1'b1;
            busy = 1'b0;
          end else begin
            chan_raw[q.rx[15:12]] = q.rx[11:2];
            if (q.last) begin
              if (!on_color) begin
                port_idx = port_idx + 2'd1;
                reading_idx = 2'd0;
              end
              r.frame_done = 1'b1;
              busy = 1'b0;
            end
          end
        end
      end
      REQ_VOLT:  r.value = 13'((32'(chan_raw[q.chan]) * UV_PER_CODE) / 1000);
      REQ_COLOR: r.value = 13'(color_raw[{q.port, q.step}]);
      default: ;
    endcase
    r.stopped = halted;
  endfunction

  function automatic request_t random_request(input logic [2:0] kind);
    logic [31:0] bits;
    request_t    q;
    bits = $urandom;
    q = bits[$bits(request_t)-1:0];
    q.kind = kind;
    q.err = 1'b0;
    q.last = 1'b0;
    return q;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      error_count++;
    end
  endfunction

  task automatic compare_result();
    result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: result with none expected, expected none got command %0h value %0d",
               $time, command_word_o, read_value_o);
      error_count++;
      return;
    end
    e = pending_results.pop_front();
    check_field("command_valid", 16'(e.cmd_valid), 16'(command_valid_o));
    check_field("command_word", e.cmd_word, command_word_o);
    check_field("use_scan_frame", 16'(e.use_scan), 16'(use_scan_frame_o));
    check_field("interval_code", 16'(e.interval), 16'(interval_code_o));
    check_field("frame_done", 16'(e.frame_done), 16'(frame_done_o));
    check_field("read_value", 16'(e.value), 16'(read_value_o));
    check_field("stopped", 16'(e.stopped), 16'(stopped_o));
  endtask

  // Offer one request, hold it until taken, then predict its result.
  task automatic issue(input request_t q, output result_t r);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= q.kind;
    rx_word_i    <= q.rx;
    last_word_i  <= q.last;
    spi_error_i  <= q.err;
    channel_i    <= q.chan;
    port_i       <= q.port;
    color_step_i <= q.step;
    do @(posedge clk_i); while (!in_ready_o);
    advance_sequencer(q, r);
    pending_results.push_back(r);
    sent_count++;
  endtask

  task automatic send_reply(input logic [2:0] kind, input logic [15:0] rx, input logic last);
    request_t q;
    result_t  r;
    q = random_request(kind);
    q.rx = rx;
    q.last = last;
    issue(q, r);
  endtask

  task automatic send_read(input logic [2:0] kind, input logic [3:0] chan,
                           input logic [1:0] port, input logic [1:0] step);
    request_t q;
    result_t  r;
    q = random_request(kind);
    q.chan = chan;
    q.port = port;
    q.step = step;
    issue(q, r);
  endtask

  task automatic send_random_read();
    result_t r;
    issue(random_request($urandom_range(0, 1) ? REQ_VOLT : REQ_COLOR), r);
  endtask

  // Drop valid and let every result drain before touching registers.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    want = '0;
    case (idx)
      REG_COLOR_MASK: begin
        color_mask_cfg = val[3:0];
        want[3:0] = val[3:0];
      end
      REG_PORT_MAP: begin
        port_map_cfg = val[15:0];
        want[15:0] = val[15:0];
      end
      REG_SENSORS: begin
        sensors_cfg = val[0];
        want[0] = val[0];
      end
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d readback expected %0h got %0h", $time, idx, want, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] mask, input logic [31:0] map,
                            input logic [31:0] sensors);
    drain_results();
    write_reg(REG_COLOR_MASK, mask);
    write_reg(REG_PORT_MAP, map);
    write_reg(REG_SENSORS, sensors);
  endtask

  // One poll: tick, then the reply the issued command calls for, with some noise.
  task automatic poll_round();
    result_t  r;
    request_t q;
    int       pick;
    int       words;
    bit       in_order;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      issue(random_request(3'($urandom_range(REQ_TICK, REQ_SPARE_HI))), r);
      return;
    end
    issue(random_request(REQ_TICK), r);
    if (r.cmd_valid && r.cmd_word == AUTO_SCAN_CMD) begin
      pick = $urandom_range(0, 9);
      words = (pick < 7) ? 16 : $urandom_range(1, 16);
      in_order = (pick != 6);
      if (pick == 9) begin
        // wrong reply kind for the command
        send_reply(REQ_SINGLE, 16'($urandom), 1'b0);
      end else begin
        for (int i = 0; i < words; i++) begin
          q = random_request(REQ_SCAN);
          if (in_order) q.rx[15:12] = 4'(i);
          q.last = (i == words - 1) && (pick != 8);
          issue(q, r);
          if ($urandom_range(0, 7) == 0) send_random_read();
        end
      end
    end else if (r.cmd_valid) begin
      send_reply(REQ_SINGLE, 16'($urandom), 1'b0);
    end else if (!r.stopped) begin
      // still busy from a broken frame: close it out
      send_reply($urandom_range(0, 1) ? REQ_SINGLE : REQ_SCAN, 16'($urandom), 1'b1);
    end
    repeat ($urandom_range(0, 2)) send_random_read();
  endtask

  task automatic run_phase(input logic [31:0] mask, input logic [31:0] map,
                           input logic [31:0] sensors, input bit sgaps, input bit rgaps,
                           input int count);
    int stop_at;
    set_config(mask, map, sensors);
    sender_gaps = sgaps;
    receiver_gaps = rgaps;
    stop_at = sent_count + count;
    while (sent_count < stop_at) poll_round();
  endtask

  task automatic test_directed();
    result_t r;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    send_read(REQ_VOLT, 4'd0, 2'd0, 2'd0);
    send_read(REQ_COLOR, 4'd15, 2'd3, 2'd3);
    issue(random_request(REQ_SPARE_LO), r);
    issue(random_request(REQ_SPARE_HI), r);
    issue(random_request(REQ_TICK), r);      // no color ports: auto scan, slow
    issue(random_request(REQ_TICK), r);      // busy: interval only
    send_reply(REQ_SCAN, 16'hFFFF, 1'b0);    // channel 15 at full scale
    send_reply(REQ_SCAN, 16'h0003, 1'b0);    // channel 0, only the spare bits set
    send_reply(REQ_SCAN, 16'h7AA8, 1'b1);
    send_read(REQ_VOLT, 4'd15, 2'd0, 2'd0);
    send_read(REQ_VOLT, 4'd0, 2'd0, 2'd0);
    // port 1 is current now; walk its readings with channel 5 mapped
    set_config(32'hF, 32'h0050, 32'h1);
    issue(random_request(REQ_TICK), r);
    send_reply(REQ_SINGLE, 16'hFFFF, 1'b0);
    issue(random_request(REQ_TICK), r);
    send_reply(REQ_SINGLE, 16'h0000, 1'b0);
    issue(random_request(REQ_TICK), r);
    send_reply(REQ_SINGLE, 16'($urandom), 1'b0);
    issue(random_request(REQ_TICK), r);      // last reading slot: auto scan
    send_reply(REQ_SCAN, 16'h1234, 1'b1);
    send_reply(REQ_SINGLE, 16'h03FF, 1'b0);  // fourth reading advances the port
    send_read(REQ_COLOR, 4'd0, 2'd1, 2'd0);
    send_read(REQ_COLOR, 4'd0, 2'd1, 2'd3);
  endtask

  task automatic test_config_sweep();
    run_phase(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 290);
    run_phase(32'hF, 32'hFFFF, 32'h1, 1'b1, 1'b1, 290);
    run_phase($urandom, $urandom, 32'h1, 1'b1, 1'b0, 290);
    run_phase(32'hF, $urandom, 32'h0, 1'b0, 1'b1, 290);
    run_phase($urandom, $urandom, $urandom, 1'b1, 1'b1, 290);
    run_phase(32'h0, 32'hFFFF, 32'h1, 1'b1, 1'b1, 290);
  endtask

  // Hold the output off while requests keep coming, so the pipeline backs up.
  task automatic test_backpressure();
    int stop_at;
    set_config(32'hF, $urandom, 32'h1);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    hold_requests++;
    stop_at = sent_count + 60;
    while (sent_count < stop_at) poll_round();
  endtask

  // A failed transfer stops the block for good, so this runs last.
  task automatic test_spi_error();
    request_t q;
    result_t  r;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    if ($urandom_range(0, 1)) begin
      issue(random_request(REQ_TICK), r);
      repeat (3) send_reply(REQ_SCAN, 16'($urandom), 1'b0);
      q = random_request(REQ_SCAN);
    end else begin
      issue(random_request(REQ_TICK), r);
      q = random_request(REQ_SINGLE);
    end
    q.err = 1'b1;
    issue(q, r);
    repeat (40) begin
      q = random_request(3'($urandom_range(REQ_TICK, REQ_SPARE_HI)));
      q.err = 1'($urandom_range(0, 1));
      q.last = 1'($urandom_range(0, 1));
      issue(q, r);
    end
    for (int c = 0; c < 16; c++) send_read(REQ_VOLT, 4'(c), 2'd0, 2'd0);
  endtask

  // Result side: per-result stall draw plus an occasional long hold-off.
  initial begin
    int stall;
    int hold_left;
    int hold_seen;
    stall = 0;
    hold_left = 0;
    hold_seen = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        compare_result();
        stall = receiver_gaps ? $urandom_range(0, 19) : 0;
      end else if (stall > 0) begin
        stall--;
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ready_i <= (stall == 0) && (hold_left == 0);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    req_type_i = REQ_TICK;
    rx_word_i = '0;
    last_word_i = 1'b0;
    spi_error_i = 1'b0;
    channel_i = '0;
    port_i = '0;
    color_step_i = '0;
    color_mask_cfg = '0;
    port_map_cfg = '0;
    sensors_cfg = 1'b0;
    scan_cmd_last = 1'b0;
    busy = 1'b0;
    halted = 1'b0;
    port_idx = '0;
    reading_idx = '0;
    foreach (chan_raw[i]) chan_raw[i] = '0;
    foreach (color_raw[i]) color_raw[i] = '0;
    error_count = 0;
    sent_count = 0;
    hold_requests = 0;
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_spi_error();

    drain_results();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
